/* rtl/float32_adder_defines.svh */
// assertion helpers for the float32 adder
`ifndef FLOAT32_ADDER_DEFINES_SVH
`define FLOAT32_ADDER_DEFINES_SVH

// property checked on every rising edge outside reset
`define FA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// signal holds its value on the edge after the condition
`define FA_ASSERT_STABLE(label, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

/* rtl/fa_pkg.sv */
package fa_pkg;

    localparam logic [31:0] FIXED_NAN = 32'h7ff00000;
    localparam logic [31:0] POS_INF   = 32'h7f800000;
    localparam logic [7:0]  EXP_MAX   = 8'hff;

    // single precision add, round to nearest even
    function automatic logic [31:0] fa_add(input logic [31:0] x, input logic [31:0] y);
        logic        xs;
        logic        ys;
        logic [7:0]  xe;
        logic [7:0]  ye;
        logic [22:0] xm;
        logic [22:0] ym;
        logic        swap;
        logic        bs;
        logic        ss;
        logic [7:0]  be;
        logic [7:0]  se;
        logic [22:0] bm;
        logic [22:0] sm;
        logic [8:0]  bee;
        logic [8:0]  see;
        logic [8:0]  gap;
        logic [26:0] big;
        logic [26:0] sml;
        logic [50:0] ext;
        logic        stk;
        logic [27:0] sum;
        logic [4:0]  p;
        logic        found;
        logic signed [10:0] eres;
        logic signed [10:0] rsh;
        logic [4:0]  r;
        logic [27:0] mant;
        logic [27:0] rem;
        logic [27:0] half;
        logic [31:0] res;
        logic        xnan;
        logic        ynan;
        begin
            xs = x[31];
            ys = y[31];
            xe = x[30:23];
            ye = y[30:23];
            xm = x[22:0];
            ym = y[22:0];
            xnan = (xe == EXP_MAX) && (xm != 23'd0);
            ynan = (ye == EXP_MAX) && (ym != 23'd0);
            swap = y[30:0] > x[30:0];
            bs = swap ? ys : xs;
            ss = swap ? xs : ys;
            be = swap ? ye : xe;
            se = swap ? xe : ye;
            bm = swap ? ym : xm;
            sm = swap ? xm : ym;
            bee = (be == 8'd0) ? 9'd1 : {1'b0, be};
            see = (se == 8'd0) ? 9'd1 : {1'b0, se};
            // 24-bit significand with three guard bits
            big = {(be != 8'd0), bm, 3'b000};
            sml = {(se != 8'd0), sm, 3'b000};
            gap = bee - see;
            // alignment shift with sticky collection
            if (gap > 9'd26)
            begin
                stk = (sml != 27'd0);
                sml = 27'd0;
            end
            else
            begin
                ext = {sml, 24'd0} >> gap[4:0];
                stk = (ext[23:0] != 24'd0);
                sml = ext[50:24];
            end
            sml[0] = sml[0] | stk;
            if (bs == ss)
                sum = {1'b0, big} + {1'b0, sml};
            else
                sum = {1'b0, big} - {1'b0, sml};
            // leading one search
            p = 5'd0;
            found = 1'b0;
            for (int i = 27; i >= 0; i--)
            begin
                if (!found && sum[i])
                begin
                    p = 5'(i);
                    found = 1'b1;
                end
            end
            // hidden bit sits at bit 26, so a leading one at bit 26 keeps the exponent
            eres = $signed({2'b00, bee}) + $signed({6'd0, p}) - 11'sd26;
            if (eres >= 1)
                rsh = $signed({6'd0, p}) - 11'sd23;
            else
            begin
                rsh = 11'sd4 - $signed({2'b00, bee});
                eres = 11'sd1;
            end
            // left shift after heavy cancellation, right shift otherwise
            if (rsh < 0)
            begin
                r = 5'd0;
                mant = sum << 5'(-rsh);
            end
            else
            begin
                r = 5'(rsh);
                mant = sum >> r;
            end
            rem  = sum & ((28'd1 << r) - 28'd1);
            half = (r == 5'd0) ? 28'd0 : (28'd1 << (r - 5'd1));
            res = ((32'(eres) - 32'd1) << 23) + 32'(mant);
            if (r != 5'd0 && (rem > half || (rem == half && mant[0])))
                res = res + 32'd1;
            if (res >= POS_INF)
                res = POS_INF;
            res = {bs, res[30:0]};
            if (eres >= 11'sd255)
                res = {bs, POS_INF[30:0]};
            if (sum == 28'd0)
                res = 32'd0;
            if (x[30:0] == 31'd0 && y[30:0] == 31'd0)
                res = {xs & ys, 31'd0};
            if (ye == EXP_MAX)
                res = y;
            if (xe == EXP_MAX)
                res = x;
            if (xe == EXP_MAX && ye == EXP_MAX)
                res = (xs != ys) ? FIXED_NAN : x;
            if (xnan || ynan)
                res = FIXED_NAN;
            fa_add = res;
        end
    endfunction

endpackage

/* rtl/float32_adder.sv */
// float32 adder, round to nearest even
// stages: input register, then result register; each beat is registered in both in turn
// throughput: one beat per cycle while m_tready is high, set by the single-pass add datapath
// reset: rst_n asynchronous, clears the valid flags only; data holds no reset
`include "float32_adder_defines.svh"
module float32_adder
    import fa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a, operand_b
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // sum_bits
);

    logic        in_vld_reg;
    logic [63:0] in_dat_reg;
    logic        out_vld_reg;
    logic [31:0] out_dat_reg;
    logic        adv;

    // pipeline moves when result stage is free or drained
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv || !in_vld_reg;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_dat_reg;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_dat_reg <= s_tdata;
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_vld_reg)
            out_dat_reg <= fa_add(in_dat_reg[31:0], in_dat_reg[63:32]);
    end

    `FA_ASSERT(a_hold, (m_tvalid && !m_tready) |=> m_tvalid, "result lost under stall")
    `FA_ASSERT(a_move, (in_vld_reg && adv) |=> m_tvalid, "beat not advanced")
    `FA_ASSERT_STABLE(a_data_hold, m_tvalid && !m_tready, m_tdata, "result changed under stall")

endmodule

/* dv/float32_adder_checker.sv */
module float32_adder_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          fail_count,
    output int          pending_sums
);
    timeunit 1ns;
    timeprecision 1ps;
    import fa_pkg::*;

    logic [31:0] sum_queue[$];

    // rounded single precision sum, nearest even
    function automatic logic [31:0] predict_sum(input logic [31:0] a, input logic [31:0] b);
        logic        as;
        logic        bs;
        logic [7:0]  ae;
        logic [7:0]  be;
        logic [22:0] am;
        logic [22:0] bm;
        logic [31:0] t;
        logic [8:0]  lead_e;
        logic [8:0]  trail_e;
        logic [63:0] lead;
        logic [63:0] trail;
        logic [63:0] total;
        logic [63:0] mant;
        logic [63:0] rem;
        logic [63:0] half;
        logic [8:0]  gap;
        int          p;
        int          e_out;
        int          r;
        logic [31:0] res;
        begin
            as = a[31];
            bs = b[31];
            ae = a[30:23];
            be = b[30:23];
            am = a[22:0];
            bm = b[22:0];
            if ((ae == EXP_MAX && am != 0) || (be == EXP_MAX && bm != 0))
                return FIXED_NAN;
            if (ae == EXP_MAX && be == EXP_MAX)
                return (as != bs) ? FIXED_NAN : a;
            if (ae == EXP_MAX)
                return a;
            if (be == EXP_MAX)
                return b;
            if (a[30:0] == 0 && b[30:0] == 0)
                return {as & bs, 31'd0};
            // larger magnitude leads
            if (b[30:0] > a[30:0])
            begin
                t = a;
                a = b;
                b = t;
                as = a[31];
                bs = b[31];
                ae = a[30:23];
                be = b[30:23];
                am = a[22:0];
                bm = b[22:0];
            end
            lead_e = (ae == 0) ? 9'd1 : {1'b0, ae};
            trail_e = (be == 0) ? 9'd1 : {1'b0, be};
            lead = {8'd0, (ae != 0), am, 32'd0};
            trail = {8'd0, (be != 0), bm, 32'd0};
            gap = lead_e - trail_e;
            // align with sticky
            if (gap >= 63)
                trail = (trail != 0) ? 64'd1 : 64'd0;
            else if (gap > 0)
                trail = (trail >> gap) | ((trail & ((64'd1 << gap) - 1)) != 0);
            total = (as == bs) ? lead + trail : lead - trail;
            if (total == 0)
                return 32'd0;
            p = 63;
            while (!total[p])
                p--;
            e_out = int'(lead_e) + p - 55;
            if (e_out >= 255)
                return {as, 31'h7f800000};
            if (e_out >= 1)
                r = p - 23;
            else
            begin
                r = 33 - int'(lead_e);
                e_out = 1;
            end
            mant = total >> r;
            rem = total & ((64'd1 << r) - 1);
            half = 64'd1 << (r - 1);
            res = ((32'(e_out) - 1) << 23) + 32'(mant);
            if (rem > half || (rem == half && mant[0]))
                res = res + 1;
            if (res >= POS_INF)
                res = POS_INF;
            return {as, res[30:0]};
        end
    endfunction

    assign pending_sums = sum_queue.size();

    // predict on input beats, compare on result beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                sum_queue.push_back(predict_sum(s_tdata[31:0], s_tdata[63:32]));
            if (m_tvalid && m_tready)
            begin
                if (sum_queue.size() == 0)
                begin
                    $error("unexpected result beat sum_bits %h", m_tdata);
                    fail_count <= fail_count + 1;
                end
                else if (sum_queue[0] !== m_tdata)
                begin
                    $error("sum_bits expected %h actual %h", sum_queue[0], m_tdata);
                    fail_count <= fail_count + 1;
                    void'(sum_queue.pop_front());
                end
                else
                    void'(sum_queue.pop_front());
            end
        end
    end
endmodule

/* dv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    int          fail_count;
    int          pending_sums;

    logic [31:0] corner_vals[16] = '{
        32'h00000000, 32'h80000000, 32'h00000001, 32'h807fffff,
        32'h00800000, 32'h7f7fffff, 32'hff7fffff, 32'h7f800000,
        32'hff800000, 32'h7fc00000, 32'hff800001, 32'h3f800000,
        32'hbf800000, 32'h33800000, 32'h4b800001, 32'h80000001
    };

    float32_adder DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    float32_adder_checker u_checker
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .fail_count(fail_count),
        .pending_sums(pending_sums)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // random operand biased toward interesting exponents
    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        begin
            v = $urandom;
            case ($urandom_range(0, 9))
                0: v[30:23] = 8'd0;
                1: v[30:23] = 8'hff;
                2: v[30:23] = 8'($urandom_range(250, 254));
                3: v[30:23] = 8'($urandom_range(1, 4));
                4: v = corner_vals[$urandom_range(0, 15)];
                default: ;
            endcase
            return v;
        end
    endfunction

    // send one operand pair, held until s_tready is seen; callers often pick near exponents to exercise cancellation
    task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
        begin
            s_tvalid <= 1'b1;
            s_tdata <= {b, a};
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
        end
    endtask

    // receiver stall pattern
    initial
    begin
        int mode;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 40))
            begin
                @(posedge clk);
                m_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode) != 0);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [31:0] a;
        logic [31:0] b;
        int burst;
        int sent;
        int waited;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // corners against each other
        for (int i = 0; i < 16; i++)
            send_pair(corner_vals[i], corner_vals[(i * 7 + 3) % 16]);
        send_pair(32'h3f800000, 32'hbf800000);
        send_pair(32'h7f7fffff, 32'h7f7fffff);
        send_pair(32'h7f800000, 32'hff800000);
        send_pair(32'h80000000, 32'h80000000);
        send_pair(32'h3f800000, 32'h33800000);
        send_pair(32'h3f800001, 32'h33800000);
        send_pair(32'h00400000, 32'h00400000);
        send_pair(32'h80000001, 32'h00000000);
        // random bursts
        sent = 0;
        while (sent < 1350)
        begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst; k++)
            begin
                a = rand_operand();
                b = rand_operand();
                if ($urandom_range(0, 2) == 0)
                begin
                    b[30:23] = a[30:23] + 8'($urandom_range(0, 3)) - 8'd1;
                    b[31] = ~a[31];
                end
                send_pair(a, b);
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_sums != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_sums == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
